// ===== design/irm_pkg.sv =====
package irm_pkg;

    localparam int MAX_INTERVALS_DEF = 32;
    localparam int TIME_BITS_DEF     = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEL,
        ST_ROOM,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_SHOW,
        ST_OUT_HOLD
    } irm_state_t;

    // Status of the back end, seen by the top level checks.
    typedef struct packed {
        irm_state_t  state;
        logic [6:0]  rooms;
        logic [6:0]  loaded;
    } irm_stat_t;

endpackage

// ===== design/interval_room_assignment.sv =====
// Channel | Direction | Ports
// input   | in        | s_valid, s_ready, s_arrival_time, s_departure_time, s_batch_last
// result  | out       | m_valid, m_ready, m_interval_index, m_room_number,
//         |           | m_rooms_total, m_overflow, m_result_last
// Loading: one interval per cycle into a two-entry queue while it has room; the back
// end drains it one per cycle while loading. Per batch, each interval is placed by a
// selection scan over the interval store, then a scan over the room table; each
// result is read, shown and then held until m_ready.
// Reset is synchronous, active low; no clearing pass is needed.
// The input side fills the queue until it is full while the back end works or stalls.
module interval_room_assignment #(
    parameter int MAX_INTERVALS = irm_pkg::MAX_INTERVALS_DEF,
    parameter int TIME_BITS     = irm_pkg::TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_arrival_time,
    input  logic [31:0] s_departure_time,
    input  logic        s_batch_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_interval_index,
    output logic [6:0]  m_room_number,
    output logic [6:0]  m_rooms_total,
    output logic        m_overflow,
    output logic        m_result_last
);
    import irm_pkg::*;

    localparam int QW = 2 * TIME_BITS + 2;

    logic          f_valid, f_ready;
    logic [QW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [QW-1:0] b_data;
    irm_stat_t     stat;

    irm_front #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_BITS(TIME_BITS)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_arrival_time   (s_arrival_time),
        .s_departure_time (s_departure_time),
        .s_batch_last     (s_batch_last),
        .q_ready          (f_ready),
        .q_valid          (f_valid),
        .q_data           (f_data)
    );

    irm_queue #(.WIDTH(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    irm_back #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_BITS(TIME_BITS)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (b_valid),
        .q_ready          (b_ready),
        .q_data           (b_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interval_index (m_interval_index),
        .m_room_number    (m_room_number),
        .m_rooms_total    (m_rooms_total),
        .m_overflow       (m_overflow),
        .m_result_last    (m_result_last),
        .stat             (stat)
    );

`ifndef SYNTH
    a_valid_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> stat.state == ST_OUT_HOLD)
        else $error("result valid outside hold state");

    a_room_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_room_number >= 7'd1) && (m_room_number <= m_rooms_total))
        else $error("room number outside the rooms in use");

    a_rooms_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.rooms <= stat.loaded)
        else $error("more rooms than loaded intervals");

    a_last_ends_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_result_last |=> stat.state == ST_LOAD && stat.loaded == 7'd0)
        else $error("batch state not cleared after last result");
`endif

endmodule

// ===== design/irm_ram.sv =====
module irm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== design/irm_queue.sv =====
module irm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_data;
        end
    end

endmodule

// ===== design/irm_front.sv =====
module irm_front #(
    parameter int MAX_INTERVALS = 32,
    parameter int TIME_BITS     = 32,
    parameter int CNT_W         = $clog2(MAX_INTERVALS + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [31:0]              s_arrival_time,
    input  logic [31:0]              s_departure_time,
    input  logic                     s_batch_last,
    input  logic                     q_ready,
    output logic                     q_valid,
    output logic [2*TIME_BITS+1:0]   q_data
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             keep;
    logic             acc;

    // Items past capacity are tagged as dropped; the back end only flags them.
    assign keep    = (cnt_reg < CNT_W'(MAX_INTERVALS));
    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign acc     = s_valid && q_ready;
    assign q_data  = {TIME_BITS'(s_arrival_time), TIME_BITS'(s_departure_time),
                      s_batch_last, keep};

    always_comb begin
        cnt_next = cnt_reg;
        if (acc) begin
            if (s_batch_last) begin
                cnt_next = '0;
            end else if (keep) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/irm_back.sv =====
module irm_back #(
    parameter int MAX_INTERVALS = 32,
    parameter int TIME_BITS     = 32,
    parameter int CNT_W         = $clog2(MAX_INTERVALS + 1),
    parameter int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  logic [2*TIME_BITS+1:0]  q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [5:0]              m_interval_index,
    output logic [6:0]              m_room_number,
    output logic [6:0]              m_rooms_total,
    output logic                    m_overflow,
    output logic                    m_result_last,
    output irm_pkg::irm_stat_t      stat
);
    import irm_pkg::*;

    localparam int TB = TIME_BITS;

    irm_state_t st_reg, st_next;

    logic [CNT_W-1:0] n_reg, n_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [MAX_INTERVALS-1:0] done_reg, done_next;
    logic [TB-1:0]    bdep_reg, bdep_next, barr_reg, barr_next;
    logic [IDX_W-1:0] bidx_reg, bidx_next;
    logic             bv_reg, bv_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] rooms_reg, rooms_next;
    logic [TB-1:0]    rkey_reg, rkey_next;
    logic [CNT_W-1:0] rseq_reg, rseq_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic             rv_reg, rv_next;
    logic [CNT_W-1:0] o_reg, o_next;
    logic             mv_reg, mv_next;
    logic [IDX_W-1:0] oroom_reg, oroom_next;

    // queue entry fields
    logic [TB-1:0] q_arr, q_dep;
    logic          q_last, q_keep;
    assign q_arr  = q_data[2*TB+1:TB+2];
    assign q_dep  = q_data[TB+1:2];
    assign q_last = q_data[1];
    assign q_keep = q_data[0];

    // interval store: {arrival, departure}
    logic             iv_we;
    logic [IDX_W-1:0] iv_raddr;
    logic [2*TB-1:0]  iv_rdata;
    logic [TB-1:0]    c_arr, c_dep;
    assign c_arr = iv_rdata[2*TB-1:TB];
    assign c_dep = iv_rdata[TB-1:0];

    irm_ram #(.WIDTH(2*TB), .DEPTH(MAX_INTERVALS), .AW(IDX_W)) u_iv_ram (
        .aclk  (aclk),
        .we    (iv_we),
        .waddr (n_reg[IDX_W-1:0]),
        .wdata ({q_arr, q_dep}),
        .raddr (iv_raddr),
        .rdata (iv_rdata)
    );

    // room table: {key, entry sequence}
    logic             rm_we;
    logic [IDX_W-1:0] rm_waddr;
    logic [IDX_W-1:0] rm_raddr;
    logic [TB+CNT_W-1:0] rm_rdata;
    logic [TB-1:0]    c_key;
    logic [CNT_W-1:0] c_seq;
    assign c_key = rm_rdata[TB+CNT_W-1:CNT_W];
    assign c_seq = rm_rdata[CNT_W-1:0];

    irm_ram #(.WIDTH(TB + CNT_W), .DEPTH(MAX_INTERVALS), .AW(IDX_W)) u_room_ram (
        .aclk  (aclk),
        .we    (rm_we),
        .waddr (rm_waddr),
        .wdata ({barr_reg, step_reg}),
        .raddr (rm_raddr),
        .rdata (rm_rdata)
    );

    // assigned room per interval, 0-based
    logic [IDX_W-1:0] as_rdata;

    irm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_INTERVALS), .AW(IDX_W)) u_asg_ram (
        .aclk  (aclk),
        .we    (rm_we),
        .waddr (bidx_reg),
        .wdata (rm_waddr),
        .raddr (o_reg[IDX_W-1:0]),
        .rdata (as_rdata)
    );

    logic c_ge, k_ok, k_better;
    // scanning upward, an equal (dep, arr) later index wins, so >= on arrival
    assign c_ge = (c_dep > bdep_reg) || ((c_dep == bdep_reg) && (c_arr >= barr_reg));
    assign k_ok = (c_key > bdep_reg);
    assign k_better = !rv_reg || (c_key < rkey_reg) ||
                      ((c_key == rkey_reg) && (c_seq < rseq_reg));

    assign rm_waddr = rv_reg ? ridx_reg : rooms_reg[IDX_W-1:0];

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_LOAD:     if (q_valid && q_last) st_next = ST_SEL;
            ST_SEL:      if (scan_reg == n_reg && !pv_reg) st_next = ST_ROOM;
            ST_ROOM:     if (scan_reg == rooms_reg && !pv_reg) st_next = ST_WRITE;
            ST_WRITE:    st_next = (step_reg + 1'b1 == n_reg) ? ST_OUT_RD : ST_SEL;
            ST_OUT_RD:   st_next = ST_OUT_SHOW;
            ST_OUT_SHOW: st_next = ST_OUT_HOLD;
            ST_OUT_HOLD: if (m_ready) begin
                st_next = (o_reg + 1'b1 == n_reg) ? ST_LOAD : ST_OUT_RD;
            end
            default:     st_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        scan_next  = scan_reg;
        pv_next    = 1'b0;
        pidx_next  = pidx_reg;
        done_next  = done_reg;
        bdep_next  = bdep_reg;
        barr_next  = barr_reg;
        bidx_next  = bidx_reg;
        bv_next    = bv_reg;
        step_next  = step_reg;
        rooms_next = rooms_reg;
        rkey_next  = rkey_reg;
        rseq_next  = rseq_reg;
        ridx_next  = ridx_reg;
        rv_next    = rv_reg;
        o_next     = o_reg;
        mv_next    = mv_reg;
        oroom_next = oroom_reg;
        q_ready    = 1'b0;
        iv_we      = 1'b0;
        rm_we      = 1'b0;
        iv_raddr   = scan_reg[IDX_W-1:0];
        rm_raddr   = scan_reg[IDX_W-1:0];
        case (st_reg)
            ST_LOAD: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_keep) begin
                        iv_we  = 1'b1;
                        n_next = n_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (q_last) begin
                        done_next = '0;
                        scan_next = '0;
                        bv_next   = 1'b0;
                        step_next = '0;
                    end
                end
            end
            ST_SEL: begin
                if (scan_reg != n_reg) begin
                    pv_next   = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                if (pv_reg && !done_reg[pidx_reg] && (!bv_reg || c_ge)) begin
                    bdep_next = c_dep;
                    barr_next = c_arr;
                    bidx_next = pidx_reg;
                    bv_next   = 1'b1;
                end
                if (scan_reg == n_reg && !pv_reg) begin
                    scan_next = '0;
                    rv_next   = 1'b0;
                end
            end
            ST_ROOM: begin
                if (scan_reg != rooms_reg) begin
                    pv_next   = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                if (pv_reg && k_ok && k_better) begin
                    rkey_next = c_key;
                    rseq_next = c_seq;
                    ridx_next = pidx_reg;
                    rv_next   = 1'b1;
                end
            end
            ST_WRITE: begin
                rm_we = 1'b1;
                done_next[bidx_reg] = 1'b1;
                if (!rv_reg) begin
                    rooms_next = rooms_reg + 1'b1;
                end
                step_next = step_reg + 1'b1;
                scan_next = '0;
                bv_next   = 1'b0;
                o_next    = '0;
            end
            ST_OUT_RD: begin
            end
            ST_OUT_SHOW: begin
                oroom_next = as_rdata;
                mv_next    = 1'b1;
            end
            ST_OUT_HOLD: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    o_next  = o_reg + 1'b1;
                    if (o_reg + 1'b1 == n_reg) begin
                        n_next     = '0;
                        ovf_next   = 1'b0;
                        rooms_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_LOAD;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            scan_reg  <= '0;
            pv_reg    <= 1'b0;
            done_reg  <= '0;
            bv_reg    <= 1'b0;
            step_reg  <= '0;
            rooms_reg <= '0;
            rv_reg    <= 1'b0;
            o_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            scan_reg  <= scan_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
            bv_reg    <= bv_next;
            step_reg  <= step_next;
            rooms_reg <= rooms_next;
            rv_reg    <= rv_next;
            o_reg     <= o_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg  <= pidx_next;
        bdep_reg  <= bdep_next;
        barr_reg  <= barr_next;
        bidx_reg  <= bidx_next;
        rkey_reg  <= rkey_next;
        rseq_reg  <= rseq_next;
        ridx_reg  <= ridx_next;
        oroom_reg <= oroom_next;
    end

    assign m_valid          = mv_reg;
    assign m_interval_index = 6'(o_reg);
    assign m_room_number    = 7'(oroom_reg) + 7'd1;
    assign m_rooms_total    = 7'(rooms_reg);
    assign m_overflow       = ovf_reg;
    assign m_result_last    = (o_reg + 1'b1 == n_reg);

    assign stat.state  = st_reg;
    assign stat.rooms  = 7'(rooms_reg);
    assign stat.loaded = 7'(n_reg);

endmodule

// ===== dv/tb_interval_room_assignment.sv =====
module tb_interval_room_assignment;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = irm_pkg::MAX_INTERVALS_DEF;
    localparam int WATCHDOG_LIMIT = 200000;

    // idling phases
    typedef enum int {PH_NONE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_arrival_time;
    logic [31:0] s_departure_time;
    logic        s_batch_last;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_interval_index;
    logic [6:0]  m_room_number;
    logic [6:0]  m_rooms_total;
    logic        m_overflow;
    logic        m_result_last;

    interval_room_assignment u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_arrival_time   (s_arrival_time),
        .s_departure_time (s_departure_time),
        .s_batch_last     (s_batch_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interval_index (m_interval_index),
        .m_room_number    (m_room_number),
        .m_rooms_total    (m_rooms_total),
        .m_overflow       (m_overflow),
        .m_result_last    (m_result_last)
    );

    typedef struct packed {
        logic [5:0] idx;
        logic [6:0] room;
        logic [6:0] total;
        logic       ovf;
        logic       last;
    } room_result_t;

    typedef struct {
        logic [31:0] arr;
        logic [31:0] dep;
        logic        last;
        bit          typed;
        room_result_t want;  // only for a single-interval batch
    } stim_row_t;

    // predictor state
    logic [31:0] held_arr[CAP];
    logic [31:0] held_dep[CAP];
    int          held_cnt;
    bit          held_ovf;

    room_result_t room_q[$];
    room_result_t typed_q[$];

    int          mismatches;
    int          idle_cnt;
    bit          timed_out;
    idle_phase_t phase;
    int          hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit orders_first(int a, int b);
        if (held_dep[a] != held_dep[b]) return held_dep[a] < held_dep[b];
        if (held_arr[a] != held_arr[b]) return held_arr[a] < held_arr[b];
        return a < b;
    endfunction

    // greedy partitioning of the held batch; appends one result per interval
    task automatic assign_batch();
        int          order[CAP];
        logic [31:0] key[CAP];
        int          rid[CAP];
        int          room_of[CAP];
        int          n, sz, i, j, v, p, q, iv, room;
        n = held_cnt;
        for (i = 0; i < n; i++) begin
            v = i;
            j = i;
            while (j > 0 && orders_first(v, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        sz = 0;
        for (int k = n; k > 0; k--) begin
            iv = order[k-1];
            p = 0;
            while (p < sz && key[p] <= held_dep[iv]) p++;
            if (p < sz) begin
                room = rid[p];
                for (q = p; q + 1 < sz; q++) begin
                    key[q] = key[q+1];
                    rid[q] = rid[q+1];
                end
                sz--;
            end else begin
                room = sz + 1;
            end
            room_of[iv] = room;
            p = 0;
            while (p < sz && key[p] <= held_arr[iv]) p++;
            for (q = sz; q > p; q--) begin
                key[q] = key[q-1];
                rid[q] = rid[q-1];
            end
            key[p] = held_arr[iv];
            rid[p] = room;
            sz++;
        end
        for (i = 0; i < n; i++)
            room_q.push_back('{idx: i[5:0], room: room_of[i][6:0], total: sz[6:0],
                               ovf: held_ovf, last: (i == n - 1)});
        held_cnt = 0;
        held_ovf = 0;
    endtask

    task automatic predict(input logic [31:0] arr, input logic [31:0] dep, input logic last);
        if (held_cnt < CAP) begin
            held_arr[held_cnt] = arr;
            held_dep[held_cnt] = dep;
            held_cnt++;
        end else begin
            held_ovf = 1;
        end
        if (last) assign_batch();
    endtask

    // valid stays high after an accepted transaction until the next one or an idle cycle
    task automatic send_interval(input logic [31:0] arr, input logic [31:0] dep,
                                 input logic last);
        int pct;
        pct = (phase == PH_SRC_IDLE || phase == PH_BOTH) ? 58 : 0;
        while ($urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_arrival_time   <= arr;
        s_departure_time <= dep;
        s_batch_last     <= last;
        do @(posedge aclk); while (!s_ready);
        predict(arr, dep, last);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (room_q.size() != 0 && !timed_out) @(posedge aclk);
    endtask

    task automatic random_batch(input int n, input bit narrow);
        logic [31:0] a, d;
        for (int i = 0; i < n; i++) begin
            if (narrow) begin
                a = $urandom_range(40);
                d = a + $urandom_range(12);
                if ($urandom_range(9) == 0) d = $urandom_range(40);
            end else begin
                a = $urandom();
                d = $urandom();
            end
            send_interval(a, d, i == n - 1);
        end
    endtask

    // receiver
    always @(posedge aclk) begin
        room_result_t got, exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_interval_index, m_room_number, m_rooms_total, m_overflow,
                        m_result_last};
                if (room_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    exp_r = room_q.pop_front();
                    if (typed_q.size() != 0 && got.idx == 0 && got.last) begin
                        // typed expectation must agree too
                        if (typed_q[0] != exp_r) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("typed row %p predicted %p", typed_q[0], exp_r);
                        end
                        void'(typed_q.pop_front());
                    end
                    if (got != exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else if (phase == PH_SNK_STALL || phase == PH_BOTH) begin
                m_ready <= ($urandom_range(99) >= 58);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            timed_out = 1;
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    stim_row_t rows[$];

    initial begin
        s_valid          = 1'b0;
        s_arrival_time   = '0;
        s_departure_time = '0;
        s_batch_last     = 1'b0;
        aresetn          = 1'b0;
        held_cnt   = 0;
        held_ovf   = 0;
        mismatches = 0;
        idle_cnt   = 0;
        timed_out  = 0;
        hold_cycles = 0;
        phase      = PH_NONE;

        // single-interval batches: room 1 of 1, read off directly
        rows.push_back('{32'd0, 32'd0, 1'b1, 1'b1, '{6'd0, 7'd1, 7'd1, 1'b0, 1'b1}});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                         '{6'd0, 7'd1, 7'd1, 1'b0, 1'b1}});
        rows.push_back('{32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, '{6'd0, 7'd1, 7'd1, 1'b0, 1'b1}});
        rows.push_back('{32'hAAAA_5555, 32'h5555_AAAA, 1'b1, 1'b1,
                         '{6'd0, 7'd1, 7'd1, 1'b0, 1'b1}});
        // overlapping, touching, nested and reversed intervals
        rows.push_back('{32'd1, 32'd5, 1'b0, 1'b0, '0});
        rows.push_back('{32'd5, 32'd9, 1'b0, 1'b0, '0});
        rows.push_back('{32'd6, 32'd9, 1'b0, 1'b0, '0});
        rows.push_back('{32'd2, 32'd3, 1'b0, 1'b0, '0});
        rows.push_back('{32'd10, 32'd4, 1'b0, 1'b0, '0});
        rows.push_back('{32'd6, 32'd9, 1'b1, 1'b0, '0});
        rows.push_back('{32'h0000_FFFF, 32'hFFFF_0000, 1'b0, 1'b0, '0});
        rows.push_back('{32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            if (rows[r].typed) typed_q.push_back(rows[r].want);
            send_interval(rows[r].arr, rows[r].dep, rows[r].last);
        end
        wait_drained();

        // full batch plus dropped items, the last dropped one closing the batch
        random_batch(CAP + 3, 1);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_cycles = 3000;
        random_batch(CAP, 1);
        random_batch(4, 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            phase = idle_phase_t'(ph);
            for (int b = 0; b < 6; b++)
                random_batch($urandom_range(1, 8), $urandom_range(3) != 0);
            // sender pauses until every expected result has come
            wait_drained();
        end
        phase = PH_NONE;

        repeat (2000) begin
            if (m_valid) break;
            @(posedge aclk);
        end
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && room_q.size() == 0 && typed_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
